### hdl/vsd_pkg.sv
// shared types and constants for the variable-length integer stream decoder
`default_nettype none
package vsd_pkg;

    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GROUP_W     = 7;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    localparam logic [COUNT_W-1:0] LEB_MAX_BYTES = 4'd10;
    localparam logic [COUNT_W-1:0] SQL_MAX_BYTES = 4'd9;
    localparam logic [COUNT_W-1:0] SQL_FULL_IDX  = 4'd8;

    // register indexes
    localparam logic [0:0] REG_MODE = 1'b0;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [COUNT_W-1:0] cnt;
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] byte_count;
        logic               terminated;
    } t_result;

    typedef struct packed {
        logic mode_leb128;
        logic clear;
    } t_cfg;

endpackage
`default_nettype wire

### hdl/vsd_cfg.sv
// apb configuration register for the decoder mode
`default_nettype none
module vsd_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [vsd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [vsd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [vsd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output vsd_pkg::t_cfg                          o_cfg
);

    logic r_mode;
    logic wr_mode;

    assign pready  = 1'b1;
    assign wr_mode = psel && penable && pwrite && (paddr[2:2] == vsd_pkg::REG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (wr_mode) begin
            r_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2:2] == vsd_pkg::REG_MODE) begin
            prdata = {{(vsd_pkg::APB_DATA_W-1){1'b0}}, r_mode};
        end
    end

    // any write to the mode register drops a partly decoded integer
    assign o_cfg.mode_leb128 = r_mode;
    assign o_cfg.clear       = wr_mode;

endmodule
`default_nettype wire

### hdl/vsd_step.sv
// one decode step: folds a byte into the accumulator and decides on a result
`default_nettype none
module vsd_step (
    input  wire logic                           i_mode_leb128,
    input  wire vsd_pkg::t_state                i_state,
    input  wire logic [vsd_pkg::BYTE_W-1:0]     i_byte,
    input  wire logic                           i_end,
    output vsd_pkg::t_state                     o_state,
    output vsd_pkg::t_result                    o_result
);

    logic [6:0]                     sh;
    logic [vsd_pkg::VALUE_W-1:0]    group;
    logic [vsd_pkg::VALUE_W-1:0]    acc_n;
    logic [vsd_pkg::COUNT_W-1:0]    count;
    logic [vsd_pkg::COUNT_W-1:0]    limit;
    logic                           done;

    assign sh    = {3'b000, i_state.cnt} * 7'd7;
    assign group = {{(vsd_pkg::VALUE_W-vsd_pkg::GROUP_W){1'b0}}, i_byte[6:0]};
    assign count = i_state.cnt + 4'd1;

    always_comb begin
        acc_n = i_state.acc;
        done  = !i_byte[7];
        if (i_mode_leb128) begin
            limit = vsd_pkg::LEB_MAX_BYTES;
            // group 10 keeps only bit 63, the rest falls off the top
            if (i_state.cnt < vsd_pkg::LEB_MAX_BYTES) begin
                acc_n = i_state.acc | (group << sh);
            end
        end else begin
            limit = vsd_pkg::SQL_MAX_BYTES;
            if (i_state.cnt >= vsd_pkg::SQL_FULL_IDX) begin
                acc_n = {i_state.acc[vsd_pkg::VALUE_W-9:0], i_byte};
                done  = 1'b1;
            end else begin
                acc_n = {i_state.acc[vsd_pkg::VALUE_W-8:0], i_byte[6:0]};
            end
        end
    end

    always_comb begin
        o_result = '0;
        o_state  = '0;
        if (done) begin
            o_result.valid      = 1'b1;
            o_result.value      = acc_n;
            o_result.byte_count = count;
            o_result.terminated = 1'b1;
        end else if (count >= limit || i_end) begin
            o_result.valid = 1'b1;
        end else begin
            o_state.acc = acc_n;
            o_state.cnt = count;
        end
    end

endmodule
`default_nettype wire

### hdl/varint_stream_decoder.sv
// top level of the LEB128 / SQLite varint stream decoder
//
//  port group  | dir | payload
//  s_*         | in  | tdata[7:0] data_byte, tlast buffer_end
//  m_*         | out | tdata[63:0] value, [67:64] byte_count, zero fill; tuser terminated
//  p* (apb)    | in  | register 0 at byte address 0: mode_leb128 (1 = LEB128)
//
// one byte per cycle sustained while the output is not stalled; an accepted byte
// goes from the input register through one decode step into the output register
// once that register is free or being taken. reset is synchronous and clears the
// mode, the partial integer and both valid flags. a stalled output holds its word
// while the input register still takes a byte, stalling only when both are full.
`default_nettype none
module varint_stream_decoder (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [vsd_pkg::BYTE_W-1:0]            s_tdata,  // [7:0] data_byte
    input  wire logic                                  s_tlast,  // buffer_end
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [vsd_pkg::OUT_TDATA_W-1:0]       m_tdata,  // [63:0] value, [67:64] byte_count
    output logic      [0:0]                            m_tuser,  // [0] terminated
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [vsd_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [vsd_pkg::APB_DATA_W-1:0]        pwdata,
    output logic      [vsd_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                       pready
);

    vsd_pkg::t_cfg      cfg;
    vsd_pkg::t_state    r_state;
    vsd_pkg::t_state    n_state;
    vsd_pkg::t_result   step_res;

    logic                           r_in_valid;
    logic [vsd_pkg::BYTE_W-1:0]     r_in_byte;
    logic                           r_in_end;
    logic                           r_out_valid;
    logic [vsd_pkg::VALUE_W-1:0]    r_out_value;
    logic [vsd_pkg::COUNT_W-1:0]    r_out_count;
    logic                           r_out_term;

    logic out_free;
    logic s_fire;
    logic step_go;

    vsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vsd_step u_step (
        .i_mode_leb128 (cfg.mode_leb128),
        .i_state       (r_state),
        .i_byte        (r_in_byte),
        .i_end         (r_in_end),
        .o_state       (n_state),
        .o_result      (step_res)
    );

    assign out_free = !r_out_valid || m_tready;
    assign step_go  = r_in_valid && out_free;
    assign s_tready = !r_in_valid || out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_byte <= s_tdata;
            r_in_end  <= s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (cfg.clear) begin
            r_state <= '0;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step_go && step_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go && step_res.valid) begin
            r_out_value <= step_res.value;
            r_out_count <= step_res.byte_count;
            r_out_term  <= step_res.terminated;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(vsd_pkg::OUT_TDATA_W-vsd_pkg::VALUE_W-vsd_pkg::COUNT_W){1'b0}},
                       r_out_count, r_out_value};
    assign m_tuser  = r_out_term;

endmodule
`default_nettype wire

### hdl/vsd_checker.sv
// port-level checks for the varint stream decoder, bound to the top level
`default_nettype none
module vsd_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tready,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [71:0]  m_tdata,
    input  wire logic [0:0]   m_tuser
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // an unterminated word carries value 0 and count 0
    a_unterm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[67:0] == 68'd0)
        else $error("unterminated word not zero");

    // a terminated word took between one and ten bytes
    a_term_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd10)
        else $error("terminated word with bad byte count");

    // with the output register empty the input side is always open
    a_ready_when_empty: assert property (@(posedge i_clk)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // reset leaves no word on the output
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind varint_stream_decoder vsd_checker u_vsd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

### tb/sv/tb.sv
// self-checking stream testbench for the leb128 / sqlite varint stream decoder
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_SQLITE = 1'b0;
    localparam logic MODE_LEB128 = 1'b1;
    localparam int   REG_SPARE   = 1;      // no register here, writes are dropped
    localparam int   IDLE_PCT    = 24;
    localparam int   DRAIN_SLACK = 6;
    localparam int   CYCLE_LIMIT = 400000;

    typedef logic [vsd_pkg::COUNT_W-1:0]    t_count;
    typedef logic [vsd_pkg::APB_ADDR_W-1:0] t_addr;

    typedef struct {
        logic [vsd_pkg::VALUE_W-1:0] value;
        logic [vsd_pkg::COUNT_W-1:0] byte_count;
        logic                        terminated;
    } t_varint;

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [vsd_pkg::BYTE_W-1:0]     s_tdata   = '0;   // [7:0] data_byte
    logic                           s_tlast   = 1'b0; // buffer_end
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [vsd_pkg::OUT_TDATA_W-1:0] m_tdata;         // [63:0] value, [67:64] byte_count, zero fill
    logic [0:0]                     m_tuser;          // [0] terminated
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [vsd_pkg::APB_ADDR_W-1:0] paddr     = '0;
    logic [vsd_pkg::APB_DATA_W-1:0] pwdata    = '0;
    logic [vsd_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // decoder image kept by the testbench
    logic                        dec_leb  = MODE_SQLITE;
    logic [vsd_pkg::VALUE_W-1:0] dec_acc  = '0;
    logic [vsd_pkg::COUNT_W-1:0] dec_seen = '0;
    t_varint                     pending_ints[$];

    int  mismatches = 0;
    int  cycles     = 0;
    int  hold_req   = 0;
    int  hold_left  = 0;
    bit  steady     = 1'b0;

    varint_stream_decoder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input logic [71:0] want,
                                 input logic [71:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    // one byte of the stream through the decoder image
    task automatic advance_decoder(input logic [7:0] b, input logic last);
        logic [vsd_pkg::COUNT_W-1:0] idx;
        logic [vsd_pkg::COUNT_W-1:0] limit;
        logic                        done;
        t_varint                     r;
        idx = dec_seen;
        if (dec_leb) begin
            limit = vsd_pkg::LEB_MAX_BYTES;
            if (idx < vsd_pkg::LEB_MAX_BYTES)
                dec_acc = dec_acc | (64'(b[6:0]) << (7 * idx));
            done = !b[7];
        end else begin
            limit = vsd_pkg::SQL_MAX_BYTES;
            if (idx >= vsd_pkg::SQL_FULL_IDX) begin
                dec_acc = {dec_acc[55:0], b};
                done = 1'b1;
            end else begin
                dec_acc = {dec_acc[56:0], b[6:0]};
                done = !b[7];
            end
        end
        if (done) begin
            r.value = dec_acc;
            r.byte_count = t_count'(idx + 1);
            r.terminated = 1'b1;
            pending_ints.push_back(r);
            dec_acc = '0;
            dec_seen = '0;
        end else if (t_count'(idx + 1) >= limit || last) begin
            r.value = '0;
            r.byte_count = '0;
            r.terminated = 1'b0;
            pending_ints.push_back(r);
            dec_acc = '0;
            dec_seen = '0;
        end else begin
            dec_seen = t_count'(idx + 1);
        end
    endtask

    // entered and left just after a falling edge; leaves tvalid high
    task automatic send_word(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        advance_decoder(b, last);
    endtask

    // stop the stream and let every word and any byte in flight drain
    task automatic settle;
        s_tvalid <= 1'b0;
        while (pending_ints.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input int index, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= t_addr'(4 * index);
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        logic [31:0] rd;
        apb_access(1'b1, int'(vsd_pkg::REG_MODE), {$urandom} & 32'hFFFF_FFFE | 32'(m), rd);
        dec_leb  = m;
        dec_acc  = '0;
        dec_seen = '0;
        apb_access(1'b0, int'(vsd_pkg::REG_MODE), '0, rd);
        if (rd !== 32'(dec_leb))
            note_mismatch("mode readback", 72'(dec_leb), 72'(rd));
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!steady && $urandom_range(99) < IDLE_PCT) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_varint want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_ints.size() == 0) begin
                note_mismatch("unexpected word", '0, 72'({m_tuser, m_tdata[67:0]}));
            end else begin
                want = pending_ints.pop_front();
                if (m_tdata[63:0] !== want.value)
                    note_mismatch("value", 72'(want.value), 72'(m_tdata[63:0]));
                if (m_tdata[67:64] !== want.byte_count)
                    note_mismatch("byte_count", 72'(want.byte_count), 72'(m_tdata[67:64]));
                if (m_tuser[0] !== want.terminated)
                    note_mismatch("terminated", 72'(want.terminated), 72'(m_tuser[0]));
                if (m_tdata[71:68] !== 4'h0)
                    note_mismatch("tdata fill", '0, 72'(m_tdata[71:68]));
            end
        end
    end

    // sqlite mode is the reset mode
    task automatic test_sqlite_forms;
        send_word(8'h7F, 1'b0);
        send_word(8'h81, 1'b0);
        send_word(8'h00, 1'b0);
        repeat (9) send_word(8'hFF, 1'b0);     // ninth byte is taken whole
        send_word(8'h85, 1'b1);                // buffer ends mid integer
        send_word(8'h00, 1'b1);                // terminator on the last byte
        settle();
    endtask

    task automatic test_leb128_forms;
        set_mode(MODE_LEB128);
        send_word(8'hE5, 1'b0);
        send_word(8'h8E, 1'b0);
        send_word(8'h26, 1'b0);
        repeat (9) send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b0);                // overlong: only bit 0 of the last group kept
        repeat (10) send_word(8'hFF, 1'b0);    // no terminator within ten bytes
        settle();
    endtask

    // a partial integer survives an ignored write but not a mode write
    task automatic test_partial_across_writes;
        logic [31:0] rd;
        send_word(8'h81, 1'b0);
        settle();
        apb_access(1'b1, REG_SPARE, 32'hFFFF_FFFF, rd);
        send_word(8'h01, 1'b0);
        send_word(8'h81, 1'b0);
        settle();
        set_mode(MODE_SQLITE);
        send_word(8'h05, 1'b0);
        settle();
    endtask

    task automatic send_random_ints(input int n_words);
        int          sent;
        int          len;
        int          maxlen;
        int          cut;
        logic [7:0]  b;
        logic        last;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(99) < 12) begin
                send_word(8'($urandom), $urandom_range(19) == 0);
                sent++;
            end else begin
                maxlen = dec_leb ? 10 : 9;
                len = ($urandom_range(3) == 0) ? $urandom_range(maxlen, 1)
                                               : $urandom_range(3, 1);
                cut = ($urandom_range(24) == 0) ? $urandom_range(len, 1) : 0;
                for (int k = 1; k <= len; k++) begin
                    b = 8'($urandom);
                    if (k < len)
                        b[7] = 1'b1;
                    else if (!(len == maxlen && $urandom_range(2) == 0))
                        b[7] = 1'b0;
                    last = (k == cut) || (k == len && $urandom_range(29) == 0);
                    send_word(b, last);
                    sent++;
                    if (k == cut)
                        break;
                end
            end
        end
    endtask

    // receiver holds off long enough for the input side to back up
    task automatic test_output_stall;
        set_mode(MODE_LEB128);
        steady   = 1'b1;
        hold_req = 300;
        repeat (150) send_word({1'b0, 7'($urandom)}, 1'b0);
        steady   = 1'b0;
        settle();
    endtask

    task automatic test_random_phases;
        logic m;
        m = MODE_SQLITE;
        for (int phase = 0; phase < 6; phase++) begin
            m = !m;
            set_mode(m);
            steady = (phase == 2);
            send_random_ints(190);
            steady = 1'b0;
            settle();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_sqlite_forms();
        test_leb128_forms();
        test_partial_across_writes();
        test_output_stall();
        test_random_phases();

        settle();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && pending_ints.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
